### rtl/core/lspe_pkg.sv
// ----------------------------------------------------------------------------
// lspe_pkg: shared constants for the line sensor position estimator
// Channel count, sample and accumulator widths, command and register codes,
// and the fixed values used by normalisation, centroid and smoothing.
// ----------------------------------------------------------------------------
package lspe_pkg;

    // array geometry
    localparam int CHANNELS    = 5;
    localparam int SAMPLE_BITS = 10;
    localparam int CH_W        = (CHANNELS > 2) ? $clog2(CHANNELS) : 1;

    // normalised level 0..1000
    localparam int FULL_SCALE = 1000;
    localparam int LVL_W      = 10;

    // squared weight and sums
    localparam int SQ_W      = 2 * LVL_W;
    localparam int TSUM_W    = SQ_W + $clog2(CHANNELS);
    localparam int WSUM_W    = SQ_W + $clog2(CHANNELS * (CHANNELS - 1) / 2 + 1);
    localparam int SCALED_W  = SAMPLE_BITS + LVL_W;

    // shared multiplier and divider
    localparam int MUL_W  = WSUM_W + LVL_W;
    localparam int DIV_W  = MUL_W;
    localparam int DEN_W  = TSUM_W;
    localparam int REM_W  = DEN_W + 1;
    localparam int CNT_W  = $clog2(DIV_W + 1);

    // smoothing arithmetic
    localparam int S_W        = 17;
    localparam int CENTRE     = (CHANNELS - 1) * 500;
    localparam int ROUND_BIAS = 2;

    // divide by five as a reciprocal multiply, exact for magnitudes below 2^14
    localparam int MAG_W       = 14;
    localparam int RECIP5      = 13108;
    localparam int RECIP_SHIFT = 16;

    // error word
    localparam int ERR_W     = 13;
    localparam int ERR_MAX_I = 4095;
    localparam int ERR_MIN_I = -4096;
    localparam int LOST_MAG  = CHANNELS * 500;
    localparam int LOST_POS_I = (LOST_MAG > ERR_MAX_I) ? ERR_MAX_I : LOST_MAG;
    localparam int LOST_NEG_I = (LOST_MAG > -ERR_MIN_I) ? ERR_MIN_I : -LOST_MAG;
    localparam logic signed [ERR_W-1:0] LOST_POS = ERR_W'(LOST_POS_I);
    localparam logic signed [ERR_W-1:0] LOST_NEG = ERR_W'(LOST_NEG_I);

    // commands
    localparam int FUNC_W = 2;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CAL     = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_MEASURE = 2'd2;

    // configuration registers
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_THR = 2'd1;
    localparam logic [CFG_DATA_W-1:0] LINE_THR_RST = 10'd150;
    localparam logic [CFG_DATA_W-1:0] TURN_THR_RST = 10'd400;

    // turn codes
    localparam logic [1:0] TURN_NONE  = 2'd0;
    localparam logic [1:0] TURN_LEFT  = 2'd1;
    localparam logic [1:0] TURN_RIGHT = 2'd2;
    localparam logic [1:0] TURN_CROSS = 2'd3;

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [LVL_W-1:0]       level_t;

endpackage

### rtl/core/line_sensor_position_estimator.sv
// ----------------------------------------------------------------------------
// line_sensor_position_estimator: weighted centroid of a reflectance array
// Clear, calibrate and measure commands; a measure word gives the smoothed
// line offset, a turn code and a line lost flag through one output register.
// ----------------------------------------------------------------------------
// clear and calibrate words: no result; the block stays ready for the next word
// measure word: a 20-step serial level divide per channel, then a
//   34-step centroid divide and a reciprocal multiply, both skipped when the
//   line is lost; the next word is accepted once the result is in the output register
// the level and centroid steps share one multiplier and one restoring divider
// reset: bounds to full/empty, thresholds 150/400, previous error zero
module line_sensor_position_estimator
    import lspe_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [FUNC_W-1:0]      func,
    input  logic [SAMPLE_BITS-1:0] sample_ch0,
    input  logic [SAMPLE_BITS-1:0] sample_ch1,
    input  logic [SAMPLE_BITS-1:0] sample_ch2,
    input  logic [SAMPLE_BITS-1:0] sample_ch3,
    input  logic [SAMPLE_BITS-1:0] sample_ch4,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic signed [ERR_W-1:0] position_error,
    output logic [1:0]             turn_code,
    output logic                   line_lost
);

    // sequencer codes
    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] S_IDLE  = 3'd0;
    localparam logic [ST_W-1:0] S_NORM  = 3'd1;
    localparam logic [ST_W-1:0] S_DIV   = 3'd2;
    localparam logic [ST_W-1:0] S_SQ    = 3'd3;
    localparam logic [ST_W-1:0] S_ACC   = 3'd4;
    localparam logic [ST_W-1:0] S_ACC2  = 3'd5;
    localparam logic [ST_W-1:0] S_POS   = 3'd6;
    localparam logic [ST_W-1:0] S_ROUND = 3'd7;
    // the final step shares the code space through a flag
    logic fin_reg, fin_next;

    logic [ST_W-1:0] state_reg, state_next;
    logic [ST_W-1:0] ret_reg, ret_next;

    logic [CFG_DATA_W-1:0] line_thr_reg, line_thr_next;
    logic [CFG_DATA_W-1:0] turn_thr_reg, turn_thr_next;

    sample_t min_reg [CHANNELS];
    sample_t min_next [CHANNELS];
    sample_t max_reg [CHANNELS];
    sample_t max_next [CHANNELS];
    sample_t raw_reg [CHANNELS];
    sample_t raw_next [CHANNELS];
    level_t  lvl_reg [CHANNELS];
    level_t  lvl_next [CHANNELS];
    sample_t samples [CHANNELS];

    logic signed [ERR_W-1:0] prev_reg, prev_next;
    logic [CH_W-1:0]   ch_reg, ch_next;
    logic [TSUM_W-1:0] tsum_reg, tsum_next;
    logic [WSUM_W-1:0] wsum_reg, wsum_next;
    logic              present_reg, present_next;
    logic              sign_reg, sign_next;
    logic [MUL_W-1:0]  prod_reg, prod_next;

    logic [DIV_W-1:0]  dvd_reg, dvd_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic                    out_valid_reg, out_valid_next;
    logic signed [ERR_W-1:0] err_out_reg, err_out_next;
    logic [1:0]              turn_reg, turn_next;
    logic                    lost_reg, lost_next;

    // shared multiplier
    logic [WSUM_W-1:0] mul_a;
    logic [LVL_W-1:0]  mul_b;
    logic [MUL_W-1:0]  mul_p;
    assign mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);

    // shared divider step, one quotient bit a cycle
    logic [REM_W-1:0] div_trial;
    logic             div_ge;
    assign div_trial = {rem_reg[REM_W-2:0], dvd_reg[DIV_W-1]};
    assign div_ge    = div_trial >= {1'b0, den_reg};

    assign samples[0] = sample_ch0;
    assign samples[1] = sample_ch1;
    assign samples[2] = sample_ch2;
    assign samples[3] = sample_ch3;
    assign samples[4] = sample_ch4;

    assign in_ready       = (state_reg == S_IDLE) && !fin_reg;
    assign out_valid      = out_valid_reg;
    assign position_error = err_out_reg;
    assign turn_code      = turn_reg;
    assign line_lost      = lost_reg;

    // per-channel working values
    sample_t          cur_raw, cur_min, cur_max;
    sample_t          cur_diff, cur_range;
    level_t           cur_lvl;
    logic signed [S_W-1:0] pos_s, cur_s, sum_s;
    logic [MAG_W-1:0] mag_s;
    logic [2*MAG_W-1:0] recip_p;
    logic signed [S_W:0] q_s, err_full;
    logic signed [ERR_W-1:0] err_sat;
    logic             t_left, t_right, t_centre;
    logic [1:0]       turn_val;

    assign cur_raw   = raw_reg[ch_reg];
    assign cur_min   = min_reg[ch_reg];
    assign cur_max   = max_reg[ch_reg];
    assign cur_diff  = (cur_raw > cur_min) ? cur_raw - cur_min : '0;
    assign cur_range = (cur_max > cur_min) ? cur_max - cur_min : SAMPLE_BITS'(1);
    assign cur_lvl   = (dvd_reg > DIV_W'(FULL_SCALE)) ? LVL_W'(FULL_SCALE)
                                                      : dvd_reg[LVL_W-1:0];

    // centroid to smoothed sum
    assign pos_s = signed'({1'b0, dvd_reg[S_W-2:0]});
    assign cur_s = pos_s - S_W'(CENTRE);
    assign sum_s = (cur_s <<< 2) + S_W'(prev_reg);
    assign mag_s = (sum_s < 0) ? MAG_W'(-sum_s) + MAG_W'(ROUND_BIAS)
                               : MAG_W'(sum_s) + MAG_W'(ROUND_BIAS);

    // magnitude over five by reciprocal multiply
    assign recip_p = (2*MAG_W)'(mag_s) * (2*MAG_W)'(RECIP5);

    // rounded quotient back to a signed error, saturated
    assign q_s      = signed'({1'b0, dvd_reg[S_W-1:0]});
    assign err_full = sign_reg ? -q_s : q_s;
    assign err_sat  = (err_full > (S_W+1)'(ERR_MAX_I)) ? ERR_W'(ERR_MAX_I) :
                      (err_full < (S_W+1)'(ERR_MIN_I)) ? ERR_W'(ERR_MIN_I) :
                      ERR_W'(err_full);

    // turn classification
    assign t_left   = (lvl_reg[0] > turn_thr_reg) && (lvl_reg[1] > turn_thr_reg);
    assign t_right  = (lvl_reg[CHANNELS-2] > turn_thr_reg) &&
                      (lvl_reg[CHANNELS-1] > turn_thr_reg);
    assign t_centre = lvl_reg[CHANNELS/2] > turn_thr_reg;
    assign turn_val = (t_left && t_right && t_centre) ? TURN_CROSS :
                      (t_left && t_centre)            ? TURN_LEFT  :
                      (t_right && t_centre)           ? TURN_RIGHT : TURN_NONE;

    // sequencer and datapath next state
    always_comb
    begin
        state_next     = state_reg;
        fin_next       = fin_reg;
        ret_next       = ret_reg;
        line_thr_next  = line_thr_reg;
        turn_thr_next  = turn_thr_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        raw_next       = raw_reg;
        lvl_next       = lvl_reg;
        prev_next      = prev_reg;
        ch_next        = ch_reg;
        tsum_next      = tsum_reg;
        wsum_next      = wsum_reg;
        present_next   = present_reg;
        sign_next      = sign_reg;
        prod_next      = prod_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        cnt_next       = cnt_reg;
        err_out_next   = err_out_reg;
        turn_next      = turn_reg;
        lost_next      = lost_reg;
        out_valid_next = out_valid_reg && !out_ready;
        mul_a          = '0;
        mul_b          = '0;

        // configuration writes
        if (cfg_we)
        begin
            case (cfg_index)
                REG_LINE_THR: line_thr_next = cfg_data;
                REG_TURN_THR: turn_thr_next = cfg_data;
                default: ;
            endcase
        end

        if (fin_reg)
        begin
            // result into the output register once it is free
            if (!out_valid_reg || out_ready)
            begin
                if (present_reg)
                begin
                    err_out_next = err_sat;
                    prev_next    = err_sat;
                end
                else
                begin
                    err_out_next = (prev_reg < 0) ? LOST_NEG : LOST_POS;
                end
                turn_next      = turn_val;
                lost_next      = !present_reg;
                out_valid_next = 1'b1;
                fin_next       = 1'b0;
                state_next     = S_IDLE;
            end
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        case (func)
                            FUNC_CLEAR:
                            begin
                                for (int i = 0; i < CHANNELS; i++)
                                begin
                                    min_next[i] = '1;
                                    max_next[i] = '0;
                                end
                            end
                            FUNC_CAL:
                            begin
                                for (int i = 0; i < CHANNELS; i++)
                                begin
                                    if (samples[i] < min_reg[i])
                                        min_next[i] = samples[i];
                                    if (samples[i] > max_reg[i])
                                        max_next[i] = samples[i];
                                end
                            end
                            FUNC_MEASURE:
                            begin
                                raw_next     = samples;
                                ch_next      = '0;
                                tsum_next    = '0;
                                wsum_next    = '0;
                                present_next = 1'b0;
                                state_next   = S_NORM;
                            end
                            default: ;
                        endcase
                    end
                end

                // scale the offset and start the level divide
                S_NORM:
                begin
                    mul_a        = WSUM_W'(cur_diff);
                    mul_b        = LVL_W'(FULL_SCALE);
                    dvd_next     = DIV_W'(mul_p[SCALED_W-1:0]) << (DIV_W - SCALED_W);
                    den_next     = DEN_W'(cur_range);
                    rem_next     = '0;
                    cnt_next     = CNT_W'(SCALED_W);
                    ret_next     = S_SQ;
                    state_next   = S_DIV;
                end

                S_DIV:
                begin
                    dvd_next = {dvd_reg[DIV_W-2:0], div_ge};
                    rem_next = div_ge ? div_trial - {1'b0, den_reg} : div_trial;
                    cnt_next = cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1))
                    begin
                        state_next = ret_reg;
                    end
                end

                // clamp the level and square it
                S_SQ:
                begin
                    lvl_next[ch_reg] = cur_lvl;
                    if (cur_lvl > line_thr_reg)
                        present_next = 1'b1;
                    mul_a      = WSUM_W'(cur_lvl);
                    mul_b      = cur_lvl;
                    prod_next  = mul_p;
                    state_next = S_ACC;
                end

                // weight sum, then weight times channel number
                S_ACC:
                begin
                    tsum_next  = tsum_reg + TSUM_W'(prod_reg[SQ_W-1:0]);
                    mul_a      = WSUM_W'(prod_reg[SQ_W-1:0]);
                    mul_b      = LVL_W'(ch_reg);
                    prod_next  = mul_p;
                    state_next = S_ACC2;
                end

                S_ACC2:
                begin
                    wsum_next = wsum_reg + prod_reg[WSUM_W-1:0];
                    if (ch_reg == CH_W'(CHANNELS - 1))
                    begin
                        state_next = S_POS;
                    end
                    else
                    begin
                        ch_next    = ch_reg + CH_W'(1);
                        state_next = S_NORM;
                    end
                end

                // centroid divide, or straight to the lost-line result
                S_POS:
                begin
                    if (!present_reg || tsum_reg == '0)
                    begin
                        present_next = 1'b0;
                        fin_next     = 1'b1;
                    end
                    else
                    begin
                        mul_a        = wsum_reg;
                        mul_b        = LVL_W'(FULL_SCALE);
                        dvd_next     = mul_p;
                        den_next     = tsum_reg;
                        rem_next     = '0;
                        cnt_next     = CNT_W'(DIV_W);
                        ret_next     = S_ROUND;
                        state_next   = S_DIV;
                    end
                end

                // smoothing: round (4*current + previous) / 5 by magnitude
                S_ROUND:
                begin
                    sign_next    = sum_s < 0;
                    dvd_next     = DIV_W'(recip_p[2*MAG_W-1:RECIP_SHIFT]);
                    fin_next     = 1'b1;
                end

                default: state_next = S_IDLE;
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            line_thr_reg  <= LINE_THR_RST;
            turn_thr_reg  <= TURN_THR_RST;
            prev_reg      <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                min_reg[i] <= '1;
                max_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            fin_reg       <= fin_next;
            out_valid_reg <= out_valid_next;
            line_thr_reg  <= line_thr_next;
            turn_thr_reg  <= turn_thr_next;
            prev_reg      <= prev_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
        end
    end

    // working and payload registers
    always_ff @(posedge clk)
    begin
        ret_reg     <= ret_next;
        raw_reg     <= raw_next;
        lvl_reg     <= lvl_next;
        ch_reg      <= ch_next;
        tsum_reg    <= tsum_next;
        wsum_reg    <= wsum_next;
        present_reg <= present_next;
        sign_reg    <= sign_next;
        prod_reg    <= prod_next;
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        den_reg     <= den_next;
        cnt_reg     <= cnt_next;
        err_out_reg <= err_out_next;
        turn_reg    <= turn_next;
        lost_reg    <= lost_next;
    end

    // a measure word keeps the block busy on the next cycle
    a_measure_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && func == FUNC_MEASURE |=> !in_ready)
        else $error("measure word did not start the sequencer");

    // the divider never runs with an exhausted step count
    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV && !fin_reg |-> cnt_reg != '0)
        else $error("divider running with zero steps left");

    // a lost-line result carries one of the two lost values
    a_lost_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && line_lost |-> position_error == LOST_POS ||
                                   position_error == LOST_NEG)
        else $error("lost-line result with a measured error");

endmodule

### tb/line_sensor_position_estimator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_sensor_position_estimator_test: self-checking bench for the estimator
// Drives clear, calibrate and measure words through the valid/ready input,
// keeps its own copy of the calibration bounds, thresholds and last error,
// and checks every result word field by field against that running estimate.
// Directed tests cover reset state, bound extremes, turn codes, degenerate
// ranges and threshold extremes; random traffic runs three idling phases.
// ----------------------------------------------------------------------------
module line_sensor_position_estimator_test;
    import lspe_pkg::*;

    localparam int RUN_LIMIT_NS  = 10_000_000;
    localparam int SETTLE_CYCLES = 256;

    // codes the package leaves unnamed
    localparam logic [FUNC_W-1:0]    FUNC_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef logic [CHANNELS-1:0][SAMPLE_BITS-1:0] readings_t;

    typedef struct packed {
        logic signed [ERR_W-1:0] err;
        logic [1:0]              turn;
        logic                    lost;
    } estimate_t;

    // clock, reset and block ports
    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic [FUNC_W-1:0]       func = FUNC_CLEAR;
    logic [SAMPLE_BITS-1:0]  sample_ch0 = '0;
    logic [SAMPLE_BITS-1:0]  sample_ch1 = '0;
    logic [SAMPLE_BITS-1:0]  sample_ch2 = '0;
    logic [SAMPLE_BITS-1:0]  sample_ch3 = '0;
    logic [SAMPLE_BITS-1:0]  sample_ch4 = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic signed [ERR_W-1:0] position_error;
    logic [1:0]              turn_code;
    logic                    line_lost;

    // bench copy of the block state
    sample_t                 bound_lo [CHANNELS];
    sample_t                 bound_hi [CHANNELS];
    logic signed [ERR_W-1:0] last_err;
    logic [CFG_DATA_W-1:0]   line_thr;
    logic [CFG_DATA_W-1:0]   turn_thr;

    estimate_t pending_estimates [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int fail_count = 0;
    int word_count = 0;
    int estimate_count = 0;
    int settings_count = 0;

    line_sensor_position_estimator dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .sample_ch0     (sample_ch0),
        .sample_ch1     (sample_ch1),
        .sample_ch2     (sample_ch2),
        .sample_ch3     (sample_ch3),
        .sample_ch4     (sample_ch4),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .position_error (position_error),
        .turn_code      (turn_code),
        .line_lost      (line_lost)
    );

    always #2 clk = ~clk;

    // receiver back-pressure
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // compare each result word with the oldest estimate
    always @(posedge clk)
    begin : check_results
        estimate_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_estimates.size() == 0)
            begin
                $error("result word with no estimate pending");
                fail_count++;
            end
            else
            begin
                want = pending_estimates.pop_front();
                if (position_error !== want.err)
                begin
                    $error("position_error expected %0d got %0d", want.err, position_error);
                    fail_count++;
                end
                if (turn_code !== want.turn)
                begin
                    $error("turn_code expected %0d got %0d", want.turn, turn_code);
                    fail_count++;
                end
                if (line_lost !== want.lost)
                begin
                    $error("line_lost expected %0d got %0d", want.lost, line_lost);
                    fail_count++;
                end
            end
        end
    end

    // normalised level of one channel, 0..1000
    function automatic int unsigned level_of_channel(int unsigned raw, int unsigned lo,
                                                     int unsigned hi);
        longint unsigned span;
        longint unsigned n;
        if (raw <= lo)
            return 0;
        span = (hi > lo) ? hi - lo : 1;
        n = (longint'(raw - lo) * FULL_SCALE) / span;
        return (n > FULL_SCALE) ? FULL_SCALE : int'(n);
    endfunction

    // update the bench state for one accepted word, queue any estimate
    task automatic track_word(input logic [FUNC_W-1:0] f, input readings_t r);
        int unsigned     lvl [CHANNELS];
        longint unsigned wsum;
        longint unsigned tsum;
        longint unsigned w;
        longint          pos;
        longint          cur;
        longint          s;
        longint          mag;
        longint          q;
        bit              present;
        bit              left;
        bit              right;
        bit              centre;
        estimate_t       e;
        wsum = 0;
        tsum = 0;
        present = 1'b0;
        case (f)
            FUNC_CLEAR:
            begin
                for (int i = 0; i < CHANNELS; i++)
                begin
                    bound_lo[i] = '1;
                    bound_hi[i] = '0;
                end
            end
            FUNC_CAL:
            begin
                for (int i = 0; i < CHANNELS; i++)
                begin
                    if (r[i] < bound_lo[i])
                        bound_lo[i] = r[i];
                    if (r[i] > bound_hi[i])
                        bound_hi[i] = r[i];
                end
            end
            FUNC_MEASURE:
            begin
                for (int i = 0; i < CHANNELS; i++)
                begin
                    lvl[i] = level_of_channel(r[i], bound_lo[i], bound_hi[i]);
                    if (lvl[i] > line_thr)
                        present = 1'b1;
                    w = longint'(lvl[i]) * lvl[i];
                    wsum += w * i;
                    tsum += w;
                end
                // no weight at all counts as lost
                if (tsum == 0)
                    present = 1'b0;
                left   = (lvl[0] > turn_thr) && (lvl[1] > turn_thr);
                right  = (lvl[CHANNELS-2] > turn_thr) && (lvl[CHANNELS-1] > turn_thr);
                centre = lvl[CHANNELS/2] > turn_thr;
                if (left && right && centre)
                    e.turn = TURN_CROSS;
                else if (left && centre)
                    e.turn = TURN_LEFT;
                else if (right && centre)
                    e.turn = TURN_RIGHT;
                else
                    e.turn = TURN_NONE;
                if (!present)
                begin
                    // lost line keeps the side of the last error
                    e.err = (last_err < 0) ? LOST_NEG : LOST_POS;
                end
                else
                begin
                    pos = longint'((wsum * FULL_SCALE) / tsum);
                    cur = pos - CENTRE;
                    // 0.8 current + 0.2 previous, rounded to nearest
                    s = 4 * cur + last_err;
                    mag = (s < 0) ? -s : s;
                    q = (mag + 2) / 5;
                    if (s < 0)
                        q = -q;
                    if (q > ERR_MAX_I)
                        q = ERR_MAX_I;
                    if (q < ERR_MIN_I)
                        q = ERR_MIN_I;
                    e.err = q[ERR_W-1:0];
                    last_err = e.err;
                end
                e.lost = !present;
                pending_estimates.push_back(e);
                estimate_count++;
            end
            default:
            begin
                // unused command: no result, no state change
            end
        endcase
    endtask

    // send one word, with a random idle gap in front of it
    task automatic send_word(input logic [FUNC_W-1:0] f, input readings_t r);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        func       <= f;
        sample_ch0 <= r[0];
        sample_ch1 <= r[1];
        sample_ch2 <= r[2];
        sample_ch3 <= r[3];
        sample_ch4 <= r[4];
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        track_word(f, r);
        word_count++;
    endtask

    // stop sending and wait for every pending estimate
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_estimates.size() != 0)
            @(posedge clk);
    endtask

    // idle long enough for a clear or calibrate word to finish too
    task automatic settle();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write both thresholds, then the two spare indexes that must be ignored
    task automatic program_thresholds(input logic [CFG_DATA_W-1:0] line_val,
                                      input logic [CFG_DATA_W-1:0] turn_val);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_LINE_THR;
        cfg_data  <= line_val;
        @(posedge clk);
        line_thr = line_val;
        cfg_index <= REG_TURN_THR;
        cfg_data  <= turn_val;
        @(posedge clk);
        turn_thr = turn_val;
        cfg_index <= REG_SPARE_2;
        cfg_data  <= CFG_DATA_W'($urandom_range(1023));
        @(posedge clk);
        cfg_index <= REG_SPARE_3;
        cfg_data  <= ~line_val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        settings_count++;
    endtask

    function automatic readings_t uniform_reading(sample_t v);
        readings_t r;
        for (int i = 0; i < CHANNELS; i++)
            r[i] = v;
        return r;
    endfunction

    // full scale on the marked channels, zero elsewhere
    function automatic readings_t lit_channels(logic [CHANNELS-1:0] on);
        readings_t r;
        for (int i = 0; i < CHANNELS; i++)
            r[i] = on[i] ? '1 : '0;
        return r;
    endfunction

    function automatic readings_t random_reading();
        readings_t r;
        for (int i = 0; i < CHANNELS; i++)
            r[i] = SAMPLE_BITS'($urandom_range(1023));
        return r;
    endfunction

    // ------------------------------------------------------------------
    // directed tests
    // ------------------------------------------------------------------

    // bounds straight after reset are empty, so nothing is seen
    task automatic test_reset_state();
        send_word(FUNC_MEASURE, uniform_reading(10'd512));
        send_word(FUNC_MEASURE, uniform_reading(10'd1023));
        send_word(FUNC_UNUSED, uniform_reading(10'd1023));
        send_word(FUNC_MEASURE, uniform_reading(10'd0));
    endtask

    // full calibration span, every turn code, lost line on both sides
    task automatic test_calibration_and_turns();
        send_word(FUNC_CLEAR, uniform_reading(10'd0));
        send_word(FUNC_CAL, uniform_reading(10'd0));
        send_word(FUNC_CAL, uniform_reading(10'd1023));
        send_word(FUNC_MEASURE, uniform_reading(10'd1023));
        send_word(FUNC_MEASURE, lit_channels(5'b00111));
        send_word(FUNC_MEASURE, lit_channels(5'b11100));
        send_word(FUNC_MEASURE, lit_channels(5'b00001));
        send_word(FUNC_MEASURE, uniform_reading(10'd0));
        send_word(FUNC_MEASURE, lit_channels(5'b10000));
        send_word(FUNC_MEASURE, uniform_reading(10'd0));
    endtask

    // a single calibration point leaves max equal to min
    task automatic test_degenerate_range();
        send_word(FUNC_CLEAR, uniform_reading(10'd1023));
        send_word(FUNC_CAL, uniform_reading(10'd500));
        send_word(FUNC_MEASURE, uniform_reading(10'd501));
        send_word(FUNC_MEASURE, uniform_reading(10'd500));
        send_word(FUNC_MEASURE, uniform_reading(10'd300));
    endtask

    // thresholds at zero, at full scale and at all ones
    task automatic test_threshold_registers();
        program_thresholds(10'd0, 10'd0);
        send_word(FUNC_CLEAR, uniform_reading(10'd0));
        send_word(FUNC_CAL, uniform_reading(10'd0));
        send_word(FUNC_CAL, uniform_reading(10'd1023));
        send_word(FUNC_MEASURE, uniform_reading(10'd2));
        program_thresholds(10'd1000, 10'd1000);
        send_word(FUNC_MEASURE, uniform_reading(10'd1023));
        program_thresholds(10'd1023, 10'd1023);
        send_word(FUNC_MEASURE, lit_channels(5'b01110));
        program_thresholds(LINE_THR_RST, TURN_THR_RST);
    endtask

    // ------------------------------------------------------------------
    // random traffic: mostly clear, calibrate, measure runs, some noise
    // ------------------------------------------------------------------
    task automatic run_random(input int n_items);
        readings_t           r;
        logic [CHANNELS-1:0] on;
        logic [FUNC_W-1:0]   f;
        int                  sent;
        int                  k;
        int                  m;
        int                  lo;
        int                  hi;
        int                  v;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(99) < 6)
            begin
                // stray word of any command
                f = FUNC_W'($urandom_range(3));
                send_word(f, random_reading());
                if (f != FUNC_UNUSED)
                    sent++;
            end
            else
            begin
                send_word(FUNC_CLEAR, random_reading());
                k = $urandom_range(1, 4);
                repeat (k)
                begin
                    for (int i = 0; i < CHANNELS; i++)
                    begin
                        case ($urandom_range(2))
                            0: r[i] = SAMPLE_BITS'($urandom_range(0, 300));
                            1: r[i] = SAMPLE_BITS'($urandom_range(700, 1023));
                            default: r[i] = SAMPLE_BITS'($urandom_range(1023));
                        endcase
                    end
                    send_word(FUNC_CAL, r);
                end
                m = $urandom_range(4, 24);
                repeat (m)
                begin
                    on = CHANNELS'($urandom());
                    for (int i = 0; i < CHANNELS; i++)
                    begin
                        lo = bound_lo[i];
                        hi = bound_hi[i];
                        if ($urandom_range(4) == 0)
                            v = $urandom_range(1023);
                        else if (on[i])
                            v = hi - $urandom_range(0, 60) + $urandom_range(0, 30);
                        else
                            v = lo + $urandom_range(0, 60) - $urandom_range(0, 30);
                        if (v < 0)
                            v = 0;
                        if (v > 1023)
                            v = 1023;
                        r[i] = SAMPLE_BITS'(v);
                    end
                    send_word(FUNC_MEASURE, r);
                end
                sent += 1 + k + m;
                // now and then let the pipeline run dry
                if ($urandom_range(19) == 0)
                    drain_results();
            end
        end
    endtask

    task automatic test_random_traffic();
        send_idle_pct = 17;
        recv_idle_pct = 47;
        program_thresholds(CFG_DATA_W'($urandom_range(1000)),
                           CFG_DATA_W'($urandom_range(1000)));
        run_random(270);
        send_idle_pct = 47;
        recv_idle_pct = 17;
        program_thresholds(CFG_DATA_W'($urandom_range(400)),
                           CFG_DATA_W'($urandom_range(300, 1000)));
        run_random(270);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        program_thresholds(LINE_THR_RST, TURN_THR_RST);
        run_random(270);
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial
    begin
        for (int i = 0; i < CHANNELS; i++)
        begin
            bound_lo[i] = '1;
            bound_hi[i] = '0;
        end
        last_err = '0;
        line_thr = LINE_THR_RST;
        turn_thr = TURN_THR_RST;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 17;
        recv_idle_pct = 47;
        test_reset_state();
        test_calibration_and_turns();
        test_degenerate_range();
        test_threshold_registers();
        test_random_traffic();

        settle();
        $display("sent %0d words, checked %0d position estimates", word_count,
                 estimate_count);
        $display("covered %0d threshold settings and three idling phases", settings_count);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // run limit
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("FAILURE");
        $finish;
    end

endmodule

### filelist.f
rtl/core/lspe_pkg.sv
rtl/core/line_sensor_position_estimator.sv
tb/line_sensor_position_estimator_test.sv
